/* src/tsd_pkg.sv */
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants for the tar stream deframer
// Block geometry, field offsets, result codes and the result record.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int unsigned BlockBytes = 512;
    localparam int unsigned PosW       = 9;
    localparam int unsigned SizeW      = 36;
    localparam int unsigned SumW       = 17;
    localparam int unsigned CheckW     = 48;
    localparam int unsigned BlocksW    = SizeW - PosW + 1;

    localparam logic [PosW-1:0] PosLast     = 9'd511;
    localparam logic [PosW-1:0] ChkFirst    = 9'd148;
    localparam logic [PosW-1:0] ChkDigLast  = 9'd153;
    localparam logic [PosW-1:0] ChkLast     = 9'd155;
    localparam logic [PosW-1:0] SizeFirst   = 9'd124;
    localparam logic [PosW-1:0] SizeLast    = 9'd135;
    localparam logic [7:0]      AsciiSpace  = 8'h20;
    localparam logic [7:0]      AsciiZero   = 8'h30;
    localparam logic [7:0]      AsciiSeven  = 8'h37;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_AFTER  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SP_SKIP   = 2'd0,
        SP_DIGITS = 2'd1,
        SP_STOP   = 2'd2
    } t_parse;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_PAD     = 3'd2,
        KIND_SKIPPED = 3'd3,
        KIND_AFTER   = 3'd4,
        KIND_END     = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        VD_NONE      = 3'd0,
        VD_GOOD      = 3'd1,
        VD_BAD_SUM   = 3'd2,
        VD_END_MARK  = 3'd3,
        VD_TRUNCATED = 3'd4,
        VD_CLEAN_END = 3'd5
    } t_verdict;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        byte_out;
        logic [PosW-1:0]   block_position;
        t_verdict          verdict;
        logic [SizeW-1:0]  entry_size;
        logic              last_data;
    } t_result;

    // Header summary as seen with the last byte of the block folded in.
    typedef struct packed {
        logic              all_zero;
        logic              good;
        logic [SizeW-1:0]  size;
    } t_hdr_result;

    // Six octal ASCII digits of the header sum, most significant first.
    function automatic logic [CheckW-1:0] octal_ascii6(input logic [SumW-1:0] sum);
        logic [17:0]       wide;
        logic [CheckW-1:0] text;
        wide = {1'b0, sum};
        text = '0;
        for (int k = 0; k < 6; k++) begin
            text[8*(5-k) +: 8] = {5'b00110, wide[3*(5-k) +: 3]};
        end
        return text;
    endfunction

endpackage

/* src/tsd_header.sv */
// ----------------------------------------------------------------------------
// tsd_header: header block accumulator
// Sums the header bytes, captures the stored checksum text and parses the
// octal size field while a header block streams in.
// ----------------------------------------------------------------------------
module tsd_header
    import tsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_clear,
    input  logic [PosW-1:0]     i_pos,
    input  logic [7:0]          i_byte,
    output t_hdr_result         o_result
);

    logic [SumW-1:0]   r_sum,   n_sum;
    logic [CheckW-1:0] r_check, n_check;
    logic              r_zero,  n_zero;
    logic [SizeW-1:0]  r_size,  n_size;
    t_parse            r_parse, n_parse;

    logic              in_chk;
    logic              in_size;
    logic              is_blank;
    logic              is_digit;

    always_comb begin
        in_chk   = (i_pos >= ChkFirst) && (i_pos <= ChkLast);
        in_size  = (i_pos >= SizeFirst) && (i_pos <= SizeLast);
        is_blank = i_byte inside {AsciiSpace, [8'h09:8'h0D]};
        is_digit = (i_byte >= AsciiZero) && (i_byte <= AsciiSeven);

        n_sum   = r_sum + (in_chk ? SumW'(AsciiSpace) : SumW'(i_byte));
        n_zero  = r_zero && (i_byte == 8'h00);
        n_check = r_check;
        if ((i_pos >= ChkFirst) && (i_pos <= ChkDigLast)) begin
            n_check = {r_check[CheckW-9:0], i_byte};
        end
        n_size  = r_size;
        n_parse = r_parse;
        if (in_size) begin
            if ((r_parse == SP_SKIP) && is_blank) begin
                n_parse = SP_SKIP;
            end else if ((r_parse != SP_STOP) && is_digit) begin
                n_parse = SP_DIGITS;
                n_size  = {r_size[SizeW-4:0], i_byte[2:0]};
            end else begin
                n_parse = SP_STOP;
            end
        end

        o_result.all_zero = n_zero;
        o_result.good     = (r_check == octal_ascii6(n_sum));
        o_result.size     = r_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear || (i_step && (i_pos == PosLast))) begin
            r_sum   <= '0;
            r_check <= '0;
            r_zero  <= 1'b1;
            r_size  <= '0;
            r_parse <= SP_SKIP;
        end else if (i_step) begin
            r_sum   <= n_sum;
            r_check <= n_check;
            r_zero  <= n_zero;
            r_size  <= n_size;
            r_parse <= n_parse;
        end
    end

endmodule

/* src/tsd_skid.sv */
// ----------------------------------------------------------------------------
// tsd_skid: two-entry result buffer
// Holds the result register and one skid entry so that the upstream side
// sees a registered stall.
// ----------------------------------------------------------------------------
module tsd_skid
    import tsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_result  i_data,
    output logic     o_stall,
    output logic     o_valid,
    output t_result  o_data,
    input  logic     i_stall
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    take;
    logic    put;

    assign o_stall = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign put     = i_valid && !r_skid_valid;
    assign take    = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= put;
                r_main       <= i_data;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= put;
            r_main       <= i_data;
        end else if (put) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

/* src/tar_stream_deframer.sv */
// ----------------------------------------------------------------------------
// tar_stream_deframer: byte-wide tar archive deframer
// Classifies each archive byte, checks header checksums and sizes, and
// reports entry and stream verdicts.
// ----------------------------------------------------------------------------
// The block takes one archive byte or end-of-stream transfer per clock
// while its input stall is low and gives exactly one result per transfer,
// from a result register backed by a one-entry skid buffer; the input
// stall is registered and rises only when both entries hold results.
// Throughput is one transfer per cycle while unstalled, set by the single
// pass of per-byte logic (the 17-bit header sum feeding the checksum
// compare, and the 36-bit file byte counter). There is no clearing pass after reset.
module tar_stream_deframer
    import tsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd,
    input  logic [7:0]        i_data_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_byte_out,
    output logic [PosW-1:0]   o_block_position,
    output logic [2:0]        o_verdict,
    output logic [SizeW-1:0]  o_entry_size,
    output logic              o_last_data
);

    t_phase               r_phase,   n_phase;
    logic [PosW-1:0]      r_offset,  n_offset;
    logic                 r_good,    n_good;
    logic [BlocksW-1:0]   r_blocks,  n_blocks;
    logic [SizeW-1:0]     r_file,    n_file;

    logic                 accept;
    logic                 hdr_step;
    logic                 hdr_clear;
    t_hdr_result          hdr;
    t_result              n_res;
    t_result              out_res;

    assign accept    = i_valid && !o_stall;
    assign hdr_step  = accept && (i_cmd == CMD_BYTE) && (r_phase == PH_HEADER);
    assign hdr_clear = accept && (i_cmd == CMD_END);

    tsd_header u_header (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (hdr_step),
        .i_clear  (hdr_clear),
        .i_pos    (r_offset),
        .i_byte   (i_data_byte),
        .o_result (hdr)
    );

    always_comb begin
        n_phase  = r_phase;
        n_offset = r_offset + PosW'(1);
        n_good   = r_good;
        n_blocks = r_blocks;
        n_file   = r_file;

        n_res.kind           = KIND_HEADER;
        n_res.byte_out       = 8'h00;
        n_res.block_position = r_offset;
        n_res.verdict        = VD_NONE;
        n_res.entry_size     = '0;
        n_res.last_data      = 1'b0;

        if (i_cmd == CMD_END) begin
            n_res.kind    = KIND_END;
            n_res.verdict = (r_phase == PH_DATA) ? VD_TRUNCATED : VD_CLEAN_END;
            n_phase  = PH_HEADER;
            n_offset = '0;
            n_good   = 1'b0;
            n_blocks = '0;
            n_file   = '0;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    n_res.kind     = KIND_HEADER;
                    n_res.byte_out = i_data_byte;
                    if (r_offset == PosLast) begin
                        if (hdr.all_zero) begin
                            n_res.verdict = VD_END_MARK;
                            n_phase       = PH_AFTER;
                        end else begin
                            n_good           = hdr.good;
                            n_res.verdict    = hdr.good ? VD_GOOD : VD_BAD_SUM;
                            n_res.entry_size = hdr.size;
                            n_file           = hdr.size;
                            // Data region length in whole blocks, rounded up.
                            n_blocks = {1'b0, hdr.size[SizeW-1:PosW]}
                                     + BlocksW'(|hdr.size[PosW-1:0]);
                            n_phase  = (hdr.size != '0) ? PH_DATA : PH_HEADER;
                        end
                    end
                end
                PH_DATA: begin
                    if (!r_good) begin
                        n_res.kind = KIND_SKIPPED;
                    end else if (r_file != '0) begin
                        n_res.kind      = KIND_DATA;
                        n_res.byte_out  = i_data_byte;
                        n_res.last_data = (r_file == SizeW'(1));
                        n_file          = r_file - SizeW'(1);
                    end else begin
                        n_res.kind = KIND_PAD;
                    end
                    // The region always ends on a block boundary.
                    if (r_offset == PosLast) begin
                        n_blocks = r_blocks - BlocksW'(1);
                        if (r_blocks == BlocksW'(1)) begin
                            n_phase = PH_HEADER;
                            n_file  = '0;
                        end
                    end
                end
                PH_AFTER: begin
                    n_res.kind = KIND_AFTER;
                end
                default: begin
                    n_res.kind = KIND_AFTER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_offset <= '0;
            r_good   <= 1'b0;
            r_blocks <= '0;
            r_file   <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_good   <= n_good;
            r_blocks <= n_blocks;
            r_file   <= n_file;
        end
    end

    tsd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_data  (n_res),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (out_res),
        .i_stall (i_stall)
    );

    assign o_kind           = out_res.kind;
    assign o_byte_out       = out_res.byte_out;
    assign o_block_position = out_res.block_position;
    assign o_verdict        = out_res.verdict;
    assign o_entry_size     = out_res.entry_size;
    assign o_last_data      = out_res.last_data;

    // A data region is never entered with no blocks to cover.
    a_blocks_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_blocks != '0))
        else $error("data region with zero blocks left");

    // Only a final file byte may carry the last flag.
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_data) |-> (o_kind == KIND_DATA))
        else $error("last flag on a non-data result");

    // Header verdicts come only with the final byte of a block.
    a_verdict_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_HEADER) && (o_verdict != VD_NONE))
        |-> (o_block_position == PosLast))
        else $error("header verdict away from block end");

    // A stream end always resets the deframer to the header phase.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_END)) |=> ((r_phase == PH_HEADER) && (r_offset == '0)))
        else $error("stream end did not restore the header phase");

endmodule

/* bench/tar_stream_deframer_test.sv */
// ----------------------------------------------------------------------------
// tar_stream_deframer_test: self-checking bench for the tar stream deframer
// Streams whole tar archives built on the fly (good and corrupt headers, odd
// size fields, file data, padding, end markers, truncation and stray bytes)
// through the block under random idling and stalling. Every result is checked
// field by field against a cycle-free model of the deframer kept in a small
// scoreboard class.
// ----------------------------------------------------------------------------
import tsd_pkg::*;

class deframer_scoreboard;
    t_phase            phase;
    logic [PosW-1:0]   offset;
    logic [SumW-1:0]   hdr_sum;
    logic [CheckW-1:0] stored_sum;
    bit                zero_block;
    logic [SizeW-1:0]  size_acc;
    t_parse            parse;
    bit                entry_ok;
    logic [SizeW:0]    region_left;
    logic [SizeW-1:0]  file_left;
    t_result           expected_q[$];
    int                errors;
    int                checked;
    int                verdict_seen[8];

    function new();
        restart();
        errors = 0;
        checked = 0;
        foreach (verdict_seen[i]) verdict_seen[i] = 0;
    endfunction

    // Six octal ASCII digits of a header sum, most significant first.
    static function logic [CheckW-1:0] octal_text(logic [SumW-1:0] s);
        logic [CheckW-1:0] t;
        logic [17:0]       w;
        w = {1'b0, s};
        t = '0;
        for (int k = 5; k >= 0; k--) t = {t[39:0], 5'b00110, w[3*k +: 3]};
        return t;
    endfunction

    function void clear_header();
        hdr_sum = '0;
        stored_sum = '0;
        zero_block = 1'b1;
        size_acc = '0;
        parse = SP_SKIP;
    endfunction

    function void restart();
        phase = PH_HEADER;
        offset = '0;
        entry_ok = 1'b0;
        region_left = '0;
        file_left = '0;
        clear_header();
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Works out the result of one accepted transfer and queues it.
    function void note_input(logic cmd, logic [7:0] b);
        t_result         r;
        logic [PosW-1:0] pos;
        bit              blank;
        pos = offset;
        r = '0;
        r.kind = KIND_HEADER;
        r.verdict = VD_NONE;
        r.block_position = pos;
        if (cmd == CMD_END) begin
            r.kind = KIND_END;
            r.verdict = (phase == PH_DATA) ? VD_TRUNCATED : VD_CLEAN_END;
            restart();
        end else begin
            case (phase)
                PH_HEADER: begin
                    r.byte_out = b;
                    if (b != 8'h00) zero_block = 1'b0;
                    // The checksum field itself counts as eight spaces.
                    if (pos >= ChkFirst && pos <= ChkLast) hdr_sum = hdr_sum + AsciiSpace;
                    else hdr_sum = hdr_sum + b;
                    if (pos >= ChkFirst && pos <= ChkDigLast) stored_sum = {stored_sum[39:0], b};
                    if (pos >= SizeFirst && pos <= SizeLast) begin
                        blank = (b == AsciiSpace) || (b >= 8'h09 && b <= 8'h0D);
                        if (parse == SP_SKIP && blank) begin
                            parse = SP_SKIP;
                        end else if (parse != SP_STOP && b >= AsciiZero && b <= AsciiSeven) begin
                            parse = SP_DIGITS;
                            size_acc = {size_acc[SizeW-4:0], b[2:0]};
                        end else begin
                            parse = SP_STOP;
                        end
                    end
                    if (pos == PosLast) begin
                        if (zero_block) begin
                            r.verdict = VD_END_MARK;
                            phase = PH_AFTER;
                        end else begin
                            entry_ok = (stored_sum == octal_text(hdr_sum));
                            r.verdict = entry_ok ? VD_GOOD : VD_BAD_SUM;
                            r.entry_size = size_acc;
                            file_left = size_acc;
                            region_left = {1'b0, size_acc} + 37'd511;
                            region_left[PosW-1:0] = '0;
                            phase = (region_left != 0) ? PH_DATA : PH_HEADER;
                        end
                        clear_header();
                    end
                end
                PH_DATA: begin
                    if (!entry_ok) begin
                        r.kind = KIND_SKIPPED;
                    end else if (file_left != 0) begin
                        r.kind = KIND_DATA;
                        r.byte_out = b;
                        r.last_data = (file_left == 1);
                        file_left = file_left - 1;
                    end else begin
                        r.kind = KIND_PAD;
                    end
                    if (region_left != 0) region_left = region_left - 1;
                    if (region_left == 0) begin
                        phase = PH_HEADER;
                        file_left = '0;
                    end
                end
                default: r.kind = KIND_AFTER;
            endcase
            offset = pos + 1'b1;
        end
        expected_q.push_back(r);
    endfunction

    task report(string msg);
        if (errors < 40) $display("ERROR: %s", msg);
        errors++;
    endtask

    task check_result(t_result got);
        t_result want;
        if (expected_q.size() == 0) begin
            report($sformatf("result with nothing expected: kind %0d byte %02h",
                             got.kind, got.byte_out));
            return;
        end
        want = expected_q.pop_front();
        checked++;
        verdict_seen[int'(want.verdict)]++;
        if (got.kind !== want.kind)
            report($sformatf("result %0d kind %0d, expected %0d", checked, got.kind, want.kind));
        if (got.byte_out !== want.byte_out)
            report($sformatf("result %0d byte %02h, expected %02h",
                             checked, got.byte_out, want.byte_out));
        if (got.block_position !== want.block_position)
            report($sformatf("result %0d position %0d, expected %0d",
                             checked, got.block_position, want.block_position));
        if (got.verdict !== want.verdict)
            report($sformatf("result %0d verdict %0d, expected %0d",
                             checked, got.verdict, want.verdict));
        if (got.entry_size !== want.entry_size)
            report($sformatf("result %0d size %0h, expected %0h",
                             checked, got.entry_size, want.entry_size));
        if (got.last_data !== want.last_data)
            report($sformatf("result %0d last_data %0b, expected %0b",
                             checked, got.last_data, want.last_data));
    endtask
endclass

module tar_stream_deframer_test;

    typedef enum int {SZ_OCTAL11, SZ_OCTAL12, SZ_BLANKS, SZ_SIGNED, SZ_EMPTY} size_style_t;
    typedef enum int {CK_GOOD, CK_DIGIT, CK_SPACE, CK_NUL, CK_JUNK} sum_style_t;

    localparam int QuietLimit = 4000;
    localparam int ItemTarget = 1600;
    // Bytes that end a size field: the first two are also legal terminators.
    localparam logic [7:0] Stoppers [9] =
        '{8'h00, 8'h20, 8'h2B, 8'h2D, 8'h38, 8'h39, 8'h08, 8'h0E, 8'hFF};

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_cmd = CMD_BYTE;
    logic [7:0]       i_data_byte = 8'h00;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [2:0]       o_kind;
    logic [7:0]       o_byte_out;
    logic [PosW-1:0]  o_block_position;
    logic [2:0]       o_verdict;
    logic [SizeW-1:0] o_entry_size;
    logic             o_last_data;

    deframer_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int headers_sent = 0;
    int archives_sent = 0;

    tar_stream_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_byte_out       (o_byte_out),
        .o_block_position (o_block_position),
        .o_verdict        (o_verdict),
        .o_entry_size     (o_entry_size),
        .o_last_data      (o_last_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(t_result'({o_kind, o_byte_out, o_block_position, o_verdict,
                                       o_entry_size, o_last_data}));
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QuietLimit) begin
            $display("timeout: no transfer for %0d cycles", QuietLimit);
            $display("tar_stream_deframer_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The idling pattern moves on every hundred transfers.
    function automatic void set_phase();
        case ((items_sent / 100) % 4)
            1: begin idle_pct = 60; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 60; end
            3: begin idle_pct = 10; stall_pct = 10; end
            default: begin idle_pct = 0; stall_pct = 0; end
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] value);
        set_phase();
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_data_byte <= value;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(cmd, value);
        items_sent++;
    endtask

    // Holds the input idle until every queued result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] octal_char(logic [SizeW-1:0] v, int d);
        return {5'b00110, 3'(v >> (3 * d))};
    endfunction

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(5);
        return (k == 0) ? AsciiSpace : 8'(8 + k);
    endfunction

    function automatic size_style_t pick_style();
        int r;
        r = $urandom_range(99);
        if (r < 50) return SZ_OCTAL11;
        if (r < 65) return SZ_OCTAL12;
        if (r < 85) return SZ_BLANKS;
        if (r < 93) return SZ_SIGNED;
        return SZ_EMPTY;
    endfunction

    function automatic logic [SizeW-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 12) return '0;
        if (r < 22) begin
            case ($urandom_range(4))
                0: return 36'd1;
                1: return 36'd511;
                2: return 36'd512;
                3: return 36'd513;
                default: return 36'd1024;
            endcase
        end
        if (r < 88) return 36'($urandom_range(1, 900));
        if ($urandom_range(3) == 0) return '1;
        return {4'($urandom_range(15)), 32'($urandom)} | 36'h2000;
    endfunction

    // One header block and its data region. A non-negative cut ends the stream
    // after that many region bytes if the region is longer.
    task automatic send_entry(input logic [SizeW-1:0] size, input size_style_t style,
                              input sum_style_t sum_style, input int cut, output bit ended);
        logic [7:0]        hdr [512];
        logic [SumW-1:0]   s;
        logic [CheckW-1:0] txt;
        logic [SizeW:0]    region;
        logic [7:0]        v;
        int                p, k, n, name_len;
        longint            q, count;
        bit                tidy;
        tidy = $urandom_range(1);
        for (p = 0; p < 512; p++) hdr[p] = tidy ? 8'h00 : 8'($urandom_range(255));
        if (tidy) begin
            name_len = $urandom_range(1, 99);
            for (p = 0; p < name_len; p++) hdr[p] = 8'($urandom_range(33, 126));
            hdr[257] = 8'h75; hdr[258] = 8'h73; hdr[259] = 8'h74;
            hdr[260] = 8'h61; hdr[261] = 8'h72; hdr[262] = 8'h00;
        end
        if (style == SZ_SIGNED || style == SZ_EMPTY) size = '0;
        if (style == SZ_OCTAL11 && size >= 36'h2_0000_0000) style = SZ_OCTAL12;
        n = 1;
        while (n < 12 && (size >> (3 * n)) != 0) n++;
        case (style)
            SZ_OCTAL11: begin
                for (p = 0; p < 11; p++) hdr[124+p] = octal_char(size, 10 - p);
                hdr[135] = 8'h00;
            end
            SZ_OCTAL12: begin
                for (p = 0; p < 12; p++) hdr[124+p] = octal_char(size, 11 - p);
            end
            SZ_BLANKS: begin
                k = $urandom_range(12 - n);
                for (p = 0; p < k; p++) hdr[124+p] = pick_blank();
                for (p = 0; p < n; p++) hdr[124+k+p] = octal_char(size, n - 1 - p);
                if (k + n < 12) hdr[124+k+n] = Stoppers[$urandom_range(8)];
            end
            SZ_SIGNED: begin
                // A sign or other stray byte up front stops the parse at once.
                hdr[124] = Stoppers[$urandom_range(2, 8)];
                for (p = 1; p < 12; p++) hdr[124+p] = octal_char(36'($urandom), 0);
            end
            default: begin
                for (p = 0; p < 12; p++)
                    hdr[124+p] = $urandom_range(1) ? 8'h00 : pick_blank();
            end
        endcase
        s = '0;
        for (p = 0; p < 512; p++) s = s + ((p >= 148 && p <= 155) ? AsciiSpace : hdr[p]);
        txt = sb.octal_text(s);
        for (k = 0; k < 6; k++) hdr[148+k] = txt[8*(5-k) +: 8];
        hdr[154] = 8'h00;
        hdr[155] = AsciiSpace;
        case (sum_style)
            CK_DIGIT: begin
                k = $urandom_range(5);
                hdr[148+k] = hdr[148+k] ^ 8'(1 << $urandom_range(2));
            end
            CK_SPACE: hdr[148] = AsciiSpace;
            CK_NUL:   hdr[148 + $urandom_range(5)] = 8'h00;
            CK_JUNK:  for (k = 0; k < 6; k++) hdr[148+k] = 8'($urandom_range(255));
            default: ;
        endcase
        for (p = 0; p < 512; p++) send_item(CMD_BYTE, hdr[p]);
        headers_sent++;
        region = {1'b0, size} + 37'd511;
        region[PosW-1:0] = '0;
        ended = (cut >= 0) && (longint'(region) > cut);
        count = ended ? longint'(cut) : longint'(region);
        for (q = 0; q < count; q++) begin
            if (q < longint'(size) || $urandom_range(4) == 0) v = 8'($urandom_range(255));
            else v = 8'h00;
            send_item(CMD_BYTE, v);
        end
        if (ended) send_item(CMD_END, 8'($urandom));
    endtask

    task automatic send_end_marker(input int trailing);
        int p;
        for (p = 0; p < 512; p++) send_item(CMD_BYTE, 8'h00);
        for (p = 0; p < trailing; p++) send_item(CMD_BYTE, 8'($urandom_range(255)));
        send_item(CMD_END, 8'($urandom));
    endtask

    // New entries start only while a header block still fits before the target.
    task automatic send_archive();
        logic [SizeW-1:0] size;
        int               entries, e, r, p, n, cut;
        bit               ended;
        entries = $urandom_range(1, 4);
        ended = 1'b0;
        for (e = 0; e < entries && !ended && items_sent < ItemTarget - 512; e++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                // Raw noise, then the stream simply ends.
                n = $urandom_range(1, 1100);
                for (p = 0; p < n; p++) send_item(CMD_BYTE, 8'($urandom_range(255)));
                send_item(CMD_END, 8'($urandom));
                ended = 1'b1;
            end else begin
                size = pick_size();
                cut = -1;
                if (size > 36'd4096 || $urandom_range(99) < 6) cut = $urandom_range(700);
                send_entry(size, pick_style(),
                           (r < 75) ? CK_GOOD : sum_style_t'($urandom_range(1, 4)), cut, ended);
            end
        end
        if (!ended) begin
            r = $urandom_range(99);
            if (r < 55) begin
                send_end_marker($urandom_range(40));
            end else begin
                // A partial header or no end marker at all: both end cleanly.
                n = (r < 80) ? $urandom_range(1, 511) : 0;
                for (p = 0; p < n; p++) send_item(CMD_BYTE, 8'($urandom_range(255)));
                send_item(CMD_END, 8'($urandom));
            end
        end
        archives_sent++;
    endtask

    initial begin
        bit ended;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Stream ends straight after reset, with both byte extremes ignored.
        send_item(CMD_END, 8'h00);
        send_item(CMD_END, 8'hFF);
        // A header cut short after a few bytes is discarded cleanly.
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hA5);
        send_item(CMD_BYTE, 8'h5A);
        send_item(CMD_END, 8'h7F);

        // Largest size field, truncated a few bytes into the data.
        send_entry('1, SZ_OCTAL12, CK_GOOD, 5, ended);
        wait_drained();

        while (items_sent < ItemTarget) begin
            send_archive();
            if (archives_sent % 4 == 0) wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("streamed %0d transfers in %0d archives with %0d headers; %0d results checked",
                 items_sent, archives_sent, headers_sent, sb.checked);
        $display("verdicts: good %0d, bad checksum %0d, end marker %0d, truncated %0d, clean %0d",
                 sb.verdict_seen[VD_GOOD], sb.verdict_seen[VD_BAD_SUM],
                 sb.verdict_seen[VD_END_MARK], sb.verdict_seen[VD_TRUNCATED],
                 sb.verdict_seen[VD_CLEAN_END]);
        if (sb.errors == 0) begin
            $display("tar_stream_deframer_test: done, clean");
        end else begin
            $display("tar_stream_deframer_test: done, errors");
        end
        $finish;
    end

endmodule

/* tar_stream_deframer.f */
src/tsd_pkg.sv
src/tsd_header.sv
src/tsd_skid.sv
src/tar_stream_deframer.sv
bench/tar_stream_deframer_test.sv
